/* rtl/rfft_pkg.sv */
// rfft_pkg: shared types for the radix-2 FFT engine.
// Holds the sequencer state encoding, the operation codes and the butterfly control bundle.
// No dependencies.
package rfft_pkg;

    typedef enum logic [8:0] {
        ST_IDLE  = 9'b000000001,
        ST_RDW   = 9'b000000010,
        ST_BF_RD = 9'b000000100,
        ST_BF_MU = 9'b000001000,
        ST_BF_SU = 9'b000010000,
        ST_BF_WK = 9'b000100000,
        ST_BF_WJ = 9'b001000000,
        ST_SC_RD = 9'b010000000,
        ST_SC_WR = 9'b100000000
    } state_t;

    typedef enum logic [1:0] {
        OP_LOAD = 2'd0,
        OP_RUN  = 2'd1,
        OP_READ = 2'd2,
        OP_NONE = 2'd3
    } op_t;

    typedef struct packed {
        logic mul_en;
        logic sum_en;
        logic inverse;
    } bfly_ctrl_t;

endpackage

/* rtl/radix2_fft_engine.sv */
// Top level: in-place radix-2 DIT FFT with point memories and sequencer.
// An inverse run ends with a scaling pass that shifts every point right by the log2 length.
// Throughput: one item at a time; the butterfly sequencer sets the run time.
// Reset (aresetn, synchronous): state and output valid cleared, log2_points set to 12; counters and memory not.
// Depends on rfft_pkg and rfft_bfly.
module radix2_fft_engine #(
    parameter int MAX_LOG2      = 12,
    parameter int SAMPLE_WIDTH  = 16,
    parameter int ACC_WIDTH     = 32,
    parameter int TWIDDLE_WIDTH = 18
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [3:0]                     cfg_wr_data,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [1:0]                     s_op,
    input  logic [11:0]                    s_index,
    input  logic signed [SAMPLE_WIDTH-1:0] s_real_in,
    input  logic signed [SAMPLE_WIDTH-1:0] s_imag_in,
    input  logic                           s_inverse,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic signed [31:0]             m_real_out,
    output logic signed [31:0]             m_imag_out
);
    localparam int AW  = MAX_LOG2;
    localparam int LW  = $clog2(MAX_LOG2 + 1);
    localparam int TA  = MAX_LOG2 - 1;
    localparam int QTR = 1 << (MAX_LOG2 - 2);
    localparam int NPT = 1 << MAX_LOG2;
    localparam int XW  = (ACC_WIDTH > 32) ? ACC_WIDTH : 32;

    typedef logic signed [TWIDDLE_WIDTH-1:0] rom_t [QTR+1];

    function automatic rom_t build_rom();
        rom_t   r;
        real    a;
        longint v;
        for (int k = 0; k <= QTR; k++) begin
            a = $cos(2.0 * 3.14159265358979323846 * k / NPT) * (2.0 ** (TWIDDLE_WIDTH - 1));
            v = longint'($floor(a + 0.5));
            if (v > (longint'(1) << (TWIDDLE_WIDTH - 1)) - 1)
                v = (longint'(1) << (TWIDDLE_WIDTH - 1)) - 1;
            r[k] = TWIDDLE_WIDTH'(v);
        end
        return r;
    endfunction

    localparam rom_t COS_ROM = build_rom();

    function automatic logic signed [31:0] sat32(input logic signed [ACC_WIDTH-1:0] v);
        logic signed [XW-1:0] x;
        x = XW'(v);
        if (x > XW'(32'sh7fffffff)) return 32'sh7fffffff;
        if (x < XW'(-33'sd2147483648)) return 32'sh80000000;
        return x[31:0];
    endfunction

    rfft_pkg::state_t state_reg, state_next;

    logic [3:0]    l2_reg;
    logic [LW-1:0] l_eff;
    logic [AW-1:0] n_mask;
    logic [AW+11:0] idx_wide;
    logic [AW-1:0] idx_m, idx_rev;

    logic          inv_reg;
    logic [LW-1:0] stage_reg, stage_next;
    logic [AW-2:0] bf_reg, bf_next, nmask_b, bf_last;
    logic [AW-1:0] sc_reg, sc_next;
    logic [AW-1:0] j_addr, k_addr;
    logic [TA-1:0] t_idx;
    logic [AW-1:0] t_dbl;
    logic [TA-1:0] c_addr, s_addr;
    logic          t_hi_reg;

    logic signed [ACC_WIDTH-1:0] re_mem [NPT];
    logic signed [ACC_WIDTH-1:0] im_mem [NPT];
    logic          rd_en;
    logic [AW-1:0] rd_a, rd_b;
    logic signed [ACC_WIDTH-1:0] ra_re_reg, ra_im_reg, rb_re_reg, rb_im_reg;
    logic signed [TWIDDLE_WIDTH-1:0] tc_reg, ts_reg, wr_v;

    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic signed [ACC_WIDTH-1:0] wr_re, wr_im;

    logic signed [ACC_WIDTH-1:0] tr, ti;
    rfft_pkg::bfly_ctrl_t bctrl;

    logic          m_valid_reg, m_valid_next;
    logic signed [31:0] m_re_reg, m_im_reg, m_re_next, m_im_next;
    logic          accept;
    logic signed [ACC_WIDTH:0] dk_re, dk_im, dj_re, dj_im;

    function automatic logic signed [ACC_WIDTH-1:0] sat1(input logic signed [ACC_WIDTH:0] v);
        logic signed [ACC_WIDTH:0] hi, lo;
        hi = (ACC_WIDTH+1)'({1'b0, {(ACC_WIDTH-1){1'b1}}});
        lo = -hi - (ACC_WIDTH+1)'(1);
        if (v > hi) return hi[ACC_WIDTH-1:0];
        if (v < lo) return lo[ACC_WIDTH-1:0];
        return v[ACC_WIDTH-1:0];
    endfunction

    always_comb begin
        priority if (l2_reg == 4'd0) l_eff = LW'(1);
        else if (32'(l2_reg) > MAX_LOG2) l_eff = LW'(MAX_LOG2);
        else l_eff = LW'(l2_reg);
    end

    assign n_mask   = {AW{1'b1}} >> (AW - 32'(l_eff));
    assign idx_wide = {{AW{1'b0}}, s_index};
    assign idx_m    = idx_wide[AW-1:0] & n_mask;

    always_comb begin
        for (int b = 0; b < AW; b++) idx_rev[b] = idx_m[AW-1-b];
        idx_rev = idx_rev >> (AW - 32'(l_eff));
    end

    assign nmask_b = {(AW-1){1'b1}} >> (AW - 32'(stage_reg));
    assign bf_last = {(AW-1){1'b1}} >> (AW - 32'(l_eff));
    assign j_addr  = ({1'b0, bf_reg & ~nmask_b} << 1) | {1'b0, bf_reg & nmask_b};
    assign k_addr  = j_addr | (AW'(1) << (stage_reg - LW'(1)));
    assign t_idx   = (bf_reg & nmask_b) << (AW - 32'(stage_reg));
    assign t_dbl   = AW'(2 * QTR) - {1'b0, t_idx};
    assign c_addr  = ({1'b0, t_idx} <= AW'(QTR)) ? t_idx : t_dbl[TA-1:0];
    assign s_addr  = ({1'b0, t_idx} <= AW'(QTR)) ? (TA'(QTR) - t_idx) : (t_idx - TA'(QTR));

    assign accept  = s_valid && s_ready;
    assign s_ready = (state_reg == rfft_pkg::ST_IDLE) && (!m_valid_reg || m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) l2_reg <= 4'd12;
        else if (cfg_wr_en) l2_reg <= cfg_wr_data;
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            ra_re_reg <= re_mem[rd_a];
            ra_im_reg <= im_mem[rd_a];
            rb_re_reg <= re_mem[rd_b];
            rb_im_reg <= im_mem[rd_b];
            tc_reg    <= COS_ROM[c_addr];
            ts_reg    <= COS_ROM[s_addr];
            t_hi_reg  <= ({1'b0, t_idx} > AW'(QTR));
        end
        if (wr_en) begin
            re_mem[wr_addr] <= wr_re;
            im_mem[wr_addr] <= wr_im;
        end
    end

    assign wr_v = t_hi_reg ? -tc_reg : tc_reg;

    assign bctrl.mul_en  = (state_reg == rfft_pkg::ST_BF_MU);
    assign bctrl.sum_en  = (state_reg == rfft_pkg::ST_BF_SU);
    assign bctrl.inverse = inv_reg;

    rfft_bfly #(
        .ACC_WIDTH     (ACC_WIDTH),
        .TWIDDLE_WIDTH (TWIDDLE_WIDTH)
    ) u_bfly (
        .aclk (aclk),
        .ctrl (bctrl),
        .xr   (rb_re_reg),
        .xi   (rb_im_reg),
        .wr   (wr_v),
        .ws   (ts_reg),
        .tr   (tr),
        .ti   (ti)
    );

    assign dk_re = (ACC_WIDTH+1)'(ra_re_reg) - (ACC_WIDTH+1)'(tr);
    assign dk_im = (ACC_WIDTH+1)'(ra_im_reg) - (ACC_WIDTH+1)'(ti);
    assign dj_re = (ACC_WIDTH+1)'(ra_re_reg) + (ACC_WIDTH+1)'(tr);
    assign dj_im = (ACC_WIDTH+1)'(ra_im_reg) + (ACC_WIDTH+1)'(ti);

    always_comb begin
        state_next   = state_reg;
        stage_next   = stage_reg;
        bf_next      = bf_reg;
        sc_next      = sc_reg;
        rd_en        = 1'b0;
        rd_a         = j_addr;
        rd_b         = k_addr;
        wr_en        = 1'b0;
        wr_addr      = idx_rev;
        wr_re        = ACC_WIDTH'(s_real_in);
        wr_im        = ACC_WIDTH'(s_imag_in);
        m_valid_next = m_valid_reg && !m_ready;
        m_re_next    = m_re_reg;
        m_im_next    = m_im_reg;
        unique case (state_reg)
            rfft_pkg::ST_IDLE: begin
                if (accept) begin
                    unique case (rfft_pkg::op_t'(s_op))
                        rfft_pkg::OP_LOAD: begin
                            wr_en        = 1'b1;
                            m_valid_next = 1'b1;
                            m_re_next    = '0;
                            m_im_next    = '0;
                        end
                        rfft_pkg::OP_RUN: begin
                            stage_next = LW'(1);
                            bf_next    = '0;
                            state_next = rfft_pkg::ST_BF_RD;
                        end
                        rfft_pkg::OP_READ: begin
                            rd_en      = 1'b1;
                            rd_a       = idx_m;
                            state_next = rfft_pkg::ST_RDW;
                        end
                        rfft_pkg::OP_NONE: begin
                            m_valid_next = 1'b1;
                            m_re_next    = '0;
                            m_im_next    = '0;
                        end
                    endcase
                end
            end
            rfft_pkg::ST_RDW: begin
                m_valid_next = 1'b1;
                m_re_next    = sat32(ra_re_reg);
                m_im_next    = sat32(ra_im_reg);
                state_next   = rfft_pkg::ST_IDLE;
            end
            rfft_pkg::ST_BF_RD: begin
                rd_en      = 1'b1;
                state_next = rfft_pkg::ST_BF_MU;
            end
            rfft_pkg::ST_BF_MU: state_next = rfft_pkg::ST_BF_SU;
            rfft_pkg::ST_BF_SU: state_next = rfft_pkg::ST_BF_WK;
            rfft_pkg::ST_BF_WK: begin
                wr_en      = 1'b1;
                wr_addr    = k_addr;
                wr_re      = sat1(dk_re);
                wr_im      = sat1(dk_im);
                state_next = rfft_pkg::ST_BF_WJ;
            end
            rfft_pkg::ST_BF_WJ: begin
                wr_en   = 1'b1;
                wr_addr = j_addr;
                wr_re   = sat1(dj_re);
                wr_im   = sat1(dj_im);
                if (bf_reg != bf_last) begin
                    bf_next    = bf_reg + 1'b1;
                    state_next = rfft_pkg::ST_BF_RD;
                end else if (stage_reg != l_eff) begin
                    bf_next    = '0;
                    stage_next = stage_reg + 1'b1;
                    state_next = rfft_pkg::ST_BF_RD;
                end else if (inv_reg) begin
                    sc_next    = '0;
                    state_next = rfft_pkg::ST_SC_RD;
                end else begin
                    m_valid_next = 1'b1;
                    m_re_next    = '0;
                    m_im_next    = '0;
                    state_next   = rfft_pkg::ST_IDLE;
                end
            end
            rfft_pkg::ST_SC_RD: begin
                rd_en      = 1'b1;
                rd_a       = sc_reg;
                state_next = rfft_pkg::ST_SC_WR;
            end
            rfft_pkg::ST_SC_WR: begin
                wr_en   = 1'b1;
                wr_addr = sc_reg;
                wr_re   = ra_re_reg >>> l_eff;
                wr_im   = ra_im_reg >>> l_eff;
                if (sc_reg != n_mask) begin
                    sc_next    = sc_reg + 1'b1;
                    state_next = rfft_pkg::ST_SC_RD;
                end else begin
                    m_valid_next = 1'b1;
                    m_re_next    = '0;
                    m_im_next    = '0;
                    state_next   = rfft_pkg::ST_IDLE;
                end
            end
            default: state_next = rfft_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= rfft_pkg::ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        stage_reg <= stage_next;
        bf_reg    <= bf_next;
        sc_reg    <= sc_next;
        m_re_reg  <= m_re_next;
        m_im_reg  <= m_im_next;
        if (accept) inv_reg <= s_inverse;
    end

    assign m_valid    = m_valid_reg;
    assign m_real_out = m_re_reg;
    assign m_imag_out = m_im_reg;

`ifndef SYNTHESIS
    a_ready_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> state_reg == rfft_pkg::ST_IDLE)
        else $error("ready outside idle");
    a_read_out: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == rfft_pkg::ST_RDW |=> m_valid)
        else $error("read beat missing");
    a_busy_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == rfft_pkg::ST_BF_RD || state_reg == rfft_pkg::ST_SC_RD) |-> !m_valid)
        else $error("result pending during run");
    a_leff: assert property (@(posedge aclk) disable iff (!aresetn)
        l_eff >= LW'(1) && 32'(l_eff) <= MAX_LOG2)
        else $error("length out of range");
`endif
endmodule

/* rtl/rfft_bfly.sv */
// rfft_bfly: twiddle product of one butterfly, rounded and saturated.
// Two register stages: exact products, then rounded sum.
// Depends on rfft_pkg.
module rfft_bfly #(
    parameter int ACC_WIDTH     = 32,
    parameter int TWIDDLE_WIDTH = 18
) (
    input  logic                        aclk,
    input  rfft_pkg::bfly_ctrl_t        ctrl,
    input  logic signed [ACC_WIDTH-1:0] xr,
    input  logic signed [ACC_WIDTH-1:0] xi,
    input  logic signed [TWIDDLE_WIDTH-1:0] wr,
    input  logic signed [TWIDDLE_WIDTH-1:0] ws,
    output logic signed [ACC_WIDTH-1:0] tr,
    output logic signed [ACC_WIDTH-1:0] ti
);
    localparam int PW = ACC_WIDTH + TWIDDLE_WIDTH;
    localparam int SW = PW + 1;

    logic signed [TWIDDLE_WIDTH-1:0] wi, nwi;
    logic signed [PW-1:0] pa_reg, pb_reg, pc_reg, pd_reg;
    logic signed [SW-1:0] sr, si, rr, ri;
    logic signed [ACC_WIDTH-1:0] tr_reg, ti_reg;

    function automatic logic signed [ACC_WIDTH-1:0] sat_acc(input logic signed [SW-1:0] v);
        logic signed [SW-1:0] hi, lo;
        hi = SW'({1'b0, {(ACC_WIDTH-1){1'b1}}});
        lo = -hi - SW'(1);
        if (v > hi) return hi[ACC_WIDTH-1:0];
        if (v < lo) return lo[ACC_WIDTH-1:0];
        return v[ACC_WIDTH-1:0];
    endfunction

    assign wi  = ctrl.inverse ? ws : -ws;
    assign nwi = -wi;

    always_ff @(posedge aclk) begin
        if (ctrl.mul_en) begin
            pa_reg <= PW'(xr) * PW'(wr);
            pb_reg <= PW'(xi) * PW'(nwi);
            pc_reg <= PW'(xi) * PW'(wr);
            pd_reg <= PW'(xr) * PW'(wi);
        end
    end

    assign sr = SW'(pa_reg) + SW'(pb_reg) + (SW'(1) <<< (TWIDDLE_WIDTH - 2));
    assign si = SW'(pc_reg) + SW'(pd_reg) + (SW'(1) <<< (TWIDDLE_WIDTH - 2));
    assign rr = sr >>> (TWIDDLE_WIDTH - 1);
    assign ri = si >>> (TWIDDLE_WIDTH - 1);

    always_ff @(posedge aclk) begin
        if (ctrl.sum_en) begin
            tr_reg <= sat_acc(rr);
            ti_reg <= sat_acc(ri);
        end
    end

    assign tr = tr_reg;
    assign ti = ti_reg;
endmodule

/* dv/testbench.sv */
// Self-checking testbench for radix2_fft_engine: load, run and read beats with random
// valid/ready idling, checked against an in-bench fixed-point FFT predictor.
// Depends on rfft_pkg and the radix2_fft_engine RTL.
module testbench;

    localparam int  NMAX  = 4096;
    localparam int  QTR   = 1024;
    localparam longint LIMIT = 3000000;

    class fft_scoreboard;
        longint re_mem[NMAX];
        longint im_mem[NMAX];
        longint cos_tab[QTR+1];
        logic [3:0] log2_reg;
        longint exp_re[$];
        longint exp_im[$];
        int errors;
        int checked;

        function new();
            log2_reg = 4'd12;
            errors = 0;
            checked = 0;
            build_table();
        endfunction

        function longint unsigned mul60(longint unsigned a, longint unsigned b);
            logic [127:0] p;
            p = {64'd0, a} * {64'd0, b};
            return p[123:60];
        endfunction

        function longint unsigned series60(longint unsigned x, bit sine);
            longint unsigned x2, term, sum, d;
            x2 = mul60(x, x);
            term = sine ? x : (64'd1 << 60);
            sum = term;
            for (int n = 1; n <= 12; n++) begin
                d = sine ? (2 * n) * (2 * n + 1) : (2 * n - 1) * (2 * n);
                term = mul60(term, x2) / d;
                if (n & 1)
                    sum = sum - term;
                else
                    sum = sum + term;
            end
            return sum;
        endfunction

        function void build_table();
            longint unsigned theta, v, r;
            int a;
            for (int k = 0; k <= QTR; k++) begin
                a = (2 * k <= QTR) ? k : QTR - k;
                theta = mul60(64'h3243F6A8885A308D, longint'(a) << 49);
                v = series60(theta, 2 * k > QTR);
                r = (v + (64'd1 << 42)) >> 43;
                if (r > 131071)
                    r = 131071;
                cos_tab[k] = longint'(r);
            end
        endfunction

        function longint sat(longint v, int w);
            longint hi;
            hi = (64'sd1 <<< (w - 1)) - 1;
            if (v > hi) return hi;
            if (v < -hi - 1) return -hi - 1;
            return v;
        endfunction

        function longint mac2(longint a, longint wa, longint b, longint wb);
            longint s;
            s = a * wa + b * wb + 65536;
            return sat(s >>> 17, 32);
        endfunction

        function int eff_log2();
            if (log2_reg < 1) return 1;
            if (log2_reg > 12) return 12;
            return log2_reg;
        endfunction

        function int bitrev(int v, int bits);
            int r;
            r = 0;
            for (int i = 0; i < bits; i++) begin
                r = (r << 1) | ((v >> i) & 1);
            end
            return r;
        endfunction

        function void transform(bit inv);
            int lg, half, stride, t, j, k;
            longint wr, ws, wi, tr, ti, xr, xi;
            lg = eff_log2();
            for (int s = 1; s <= lg; s++) begin
                half = 1 << (s - 1);
                stride = 1 << (12 - s);
                for (int base = 0; base < (1 << lg); base += 2 * half) begin
                    for (int n = 0; n < half; n++) begin
                        t = n * stride;
                        j = base + n;
                        k = j + half;
                        if (t <= QTR) begin
                            wr = cos_tab[t];
                            ws = cos_tab[QTR - t];
                        end else begin
                            wr = -cos_tab[2 * QTR - t];
                            ws = cos_tab[t - QTR];
                        end
                        wi = inv ? ws : -ws;
                        xr = re_mem[k];
                        xi = im_mem[k];
                        tr = mac2(xr, wr, xi, -wi);
                        ti = mac2(xi, wr, xr, wi);
                        re_mem[k] = sat(re_mem[j] - tr, 32);
                        im_mem[k] = sat(im_mem[j] - ti, 32);
                        re_mem[j] = sat(re_mem[j] + tr, 32);
                        im_mem[j] = sat(im_mem[j] + ti, 32);
                    end
                end
            end
            if (inv) begin
                for (int n = 0; n < (1 << lg); n++) begin
                    re_mem[n] = re_mem[n] >>> lg;
                    im_mem[n] = im_mem[n] >>> lg;
                end
            end
        endfunction

        function void note(rfft_pkg::op_t op, logic [11:0] index, logic signed [15:0] rin,
                           logic signed [15:0] iin, logic inv);
            int lg, idx;
            longint r, i;
            lg = eff_log2();
            idx = index & ((1 << lg) - 1);
            r = 0;
            i = 0;
            case (op)
                rfft_pkg::OP_LOAD: begin
                    re_mem[bitrev(idx, lg)] = rin;
                    im_mem[bitrev(idx, lg)] = iin;
                end
                rfft_pkg::OP_RUN: transform(inv);
                rfft_pkg::OP_READ: begin
                    r = sat(re_mem[idx], 32);
                    i = sat(im_mem[idx], 32);
                end
                default: ;
            endcase
            exp_re.push_back(r);
            exp_im.push_back(i);
        endfunction

        task report(string msg);
            $display("mismatch: %s", msg);
            errors++;
        endtask

        task check(logic signed [31:0] r, logic signed [31:0] i);
            longint er, ei;
            if (exp_re.size() == 0) begin
                report($sformatf("unexpected beat re=%0d im=%0d", r, i));
            end else begin
                er = exp_re.pop_front();
                ei = exp_im.pop_front();
                checked++;
                if (longint'(r) != er)
                    report($sformatf("beat %0d real got %0d want %0d", checked, r, er));
                if (longint'(i) != ei)
                    report($sformatf("beat %0d imag got %0d want %0d", checked, i, ei));
            end
        endtask
    endclass

    logic aclk = 0;
    logic aresetn = 0;
    logic cfg_wr_en = 0;
    logic [3:0] cfg_wr_data = 0;
    logic s_valid = 0;
    logic s_ready;
    logic [1:0] s_op = 0;
    logic [11:0] s_index = 0;
    logic signed [15:0] s_real_in = 0;
    logic signed [15:0] s_imag_in = 0;
    logic s_inverse = 0;
    logic m_valid;
    logic m_ready = 0;
    logic signed [31:0] m_real_out;
    logic signed [31:0] m_imag_out;

    fft_scoreboard sb;
    bit quiet = 0;
    int stall_left = 0;
    longint cycles = 0;
    int filled_n = 0;
    int runs_done = 0;
    int reads_done = 0;

    always #5 aclk = ~aclk;

    radix2_fft_engine DUT (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .s_valid(s_valid), .s_ready(s_ready), .s_op(s_op), .s_index(s_index),
        .s_real_in(s_real_in), .s_imag_in(s_imag_in), .s_inverse(s_inverse),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_real_out(m_real_out), .m_imag_out(m_imag_out)
    );

    always @(posedge aclk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("FAILURE");
            $finish;
        end
        if (aresetn && m_valid && m_ready)
            sb.check(m_real_out, m_imag_out);
    end

    always @(negedge aclk) begin
        if (stall_left > 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else if (!quiet && aresetn && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 3) - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    task send(rfft_pkg::op_t op, logic [11:0] idx, logic signed [15:0] rin,
              logic signed [15:0] iin, logic inv);
        int gap;
        @(negedge aclk);
        if (!quiet && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 3);
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_op <= op;
        s_index <= idx;
        s_real_in <= rin;
        s_imag_in <= iin;
        s_inverse <= inv;
        do @(posedge aclk); while (!s_ready);
        sb.note(op, idx, rin, iin, inv);
        if (op == rfft_pkg::OP_RUN) runs_done++;
        if (op == rfft_pkg::OP_READ) reads_done++;
    endtask

    task drain();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (sb.exp_re.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task write_cfg(logic [3:0] val);
        drain();
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= val;
        @(posedge aclk);
        sb.log2_reg = val;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    function logic signed [15:0] rand_sample();
        case ($urandom_range(0, 7))
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            2: return 16'sh0000;
            default: return 16'($urandom);
        endcase
    endfunction

    task fill_store();
        int n;
        n = 1 << sb.eff_log2();
        if (n > filled_n) begin
            for (int i = 0; i < n; i++)
                send(rfft_pkg::OP_LOAD, 12'(i), rand_sample(), rand_sample(), 1'b0);
            filled_n = n;
        end
    endtask

    task phase(logic [3:0] val, int count, bit allow_run, bit pause_mid);
        int pick;
        write_cfg(val);
        fill_store();
        for (int c = 0; c < count; c++) begin
            if (pause_mid && c == count / 2)
                drain();
            pick = $urandom_range(0, 19);
            if (pick < 8)
                send(rfft_pkg::OP_LOAD, 12'($urandom), rand_sample(), rand_sample(),
                     1'($urandom));
            else if (pick < 10 && allow_run)
                send(rfft_pkg::OP_RUN, 12'($urandom), 16'($urandom), 16'($urandom),
                     1'($urandom));
            else if (pick < 19)
                send(rfft_pkg::OP_READ, 12'($urandom), 16'($urandom), 16'($urandom),
                     1'($urandom));
            else
                send(rfft_pkg::OP_NONE, 12'($urandom), 16'($urandom), 16'($urandom),
                     1'($urandom));
        end
    endtask

    task full_size(logic [3:0] val, int count);
        int idx;
        write_cfg(val);
        for (int c = 0; c < count; c++) begin
            idx = $urandom_range(0, NMAX - 1);
            send(rfft_pkg::OP_LOAD, 12'(idx), rand_sample(), rand_sample(), 1'($urandom));
            send(rfft_pkg::OP_READ, 12'(sb.bitrev(idx, 12)), 16'($urandom), 16'($urandom),
                 1'($urandom));
        end
        send(rfft_pkg::OP_NONE, 12'($urandom), 16'($urandom), 16'($urandom), 1'($urandom));
    endtask

    initial begin
        sb = new();
        repeat (11) @(negedge aclk);
        aresetn <= 1'b1;

        write_cfg(4'd2);
        send(rfft_pkg::OP_LOAD, 12'd0, 16'sh7FFF, 16'sh8000, 1'b0);
        send(rfft_pkg::OP_LOAD, 12'd1, 16'sh8000, 16'sh7FFF, 1'b0);
        send(rfft_pkg::OP_LOAD, 12'd2, 16'sh7FFF, 16'sh7FFF, 1'b0);
        send(rfft_pkg::OP_LOAD, 12'hFFF, 16'sh8000, 16'sh8000, 1'b1);
        filled_n = 4;
        send(rfft_pkg::OP_RUN, 12'd0, 16'sd0, 16'sd0, 1'b0);
        for (int i = 0; i < 4; i++)
            send(rfft_pkg::OP_READ, 12'(i), 16'sd0, 16'sd0, 1'b0);
        send(rfft_pkg::OP_RUN, 12'hFFF, 16'sh7FFF, 16'sh8000, 1'b1);
        for (int i = 0; i < 4; i++)
            send(rfft_pkg::OP_READ, 12'(i) | 12'hFFC, 16'sd0, 16'sd0, 1'b1);
        send(rfft_pkg::OP_NONE, 12'hFFF, 16'sh7FFF, 16'sh8000, 1'b1);
        send(rfft_pkg::OP_READ, 12'hFFF, 16'sd0, 16'sd0, 1'b0);

        phase(4'd1, 100, 1, 0);
        phase(4'd0, 100, 1, 0);
        phase(4'd3, 150, 1, 1);
        full_size(4'd15, 30);
        full_size(4'd12, 10);
        phase(4'd4, 200, 1, 0);
        phase(4'd5, 200, 1, 0);
        phase(4'd6, 150, 1, 0);
        quiet = 1;
        phase(4'd2, 150, 1, 0);

        drain();
        repeat (20) @(posedge aclk);
        $display("covered %0d result beats, %0d transforms up to 64 points, %0d reads",
                 sb.checked, runs_done, reads_done);
        $display("load and read checked at 4096 points, length clamped at both ends");
        if (sb.errors == 0 && sb.exp_re.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("errors %0d, left over %0d", sb.errors, sb.exp_re.size());
            $display("FAILURE");
        end
        $finish;
    end
endmodule
